/* src/mcr_pkg.sv */
// Package for the midpoint circle rasterizer: widths, the queue entry type
// and the point mirroring function. No dependencies.
`timescale 1ns / 1ps

package mcr_pkg;

  localparam int RadiusBits = 10;
  localparam int CoordW     = 11;
  localparam int DecW       = RadiusBits + 6;
  localparam int OctW       = 3;

  localparam logic [OctW-1:0] LastOctant = 3'd7;

  localparam logic OpStart = 1'b0;
  localparam logic OpStep  = 1'b1;

  // One run of eight points waiting for the back end.
  typedef struct packed {
    logic [RadiusBits-1:0] x;
    logic [RadiusBits-1:0] y;
    logic                  fin;
  } run_t;

  typedef struct packed {
    logic signed [CoordW-1:0] px;
    logic signed [CoordW-1:0] py;
  } point_t;

  function automatic point_t mirror(input logic [RadiusBits-1:0] x,
                                    input logic [RadiusBits-1:0] y,
                                    input logic [OctW-1:0] k);
    logic signed [CoordW-1:0] a;
    logic signed [CoordW-1:0] b;
    logic signed [CoordW-1:0] na;
    logic signed [CoordW-1:0] nb;
    point_t p;
    a  = CoordW'(x);
    b  = CoordW'(y);
    na = CoordW'(0) - a;
    nb = CoordW'(0) - b;
    unique case (k)
      3'd0: begin p.px = a;  p.py = b;  end
      3'd1: begin p.px = b;  p.py = a;  end
      3'd2: begin p.px = nb; p.py = a;  end
      3'd3: begin p.px = na; p.py = b;  end
      3'd4: begin p.px = na; p.py = nb; end
      3'd5: begin p.px = nb; p.py = na; end
      3'd6: begin p.px = b;  p.py = na; end
      default: begin p.px = a; p.py = nb; end
    endcase
    return p;
  endfunction

endpackage

/* src/mcr_front.sv */
// Front end: accepts start and step transactions and advances the midpoint
// state. Depends on mcr_pkg.
`timescale 1ns / 1ps

module mcr_front import mcr_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  op_i,
  input  logic [9:0]            radius_i,
  input  logic                  q_full_i,
  output logic                  push_o,
  output run_t                  run_o
);

  logic [RadiusBits-1:0] x_q, x_d;
  logic [RadiusBits-1:0] y_q, y_d;
  logic [DecW-1:0]       dec_q, dec_d;
  logic                  fin_q, fin_d;
  logic                  accept;
  logic [RadiusBits-1:0] r;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign r          = RadiusBits'(radius_i);

  always_comb begin
    x_d   = x_q;
    y_d   = y_q;
    dec_d = dec_q;
    if (op_i == OpStart) begin
      x_d   = '0;
      y_d   = r;
      dec_d = DecW'(5) - DecW'({r, 2'b00});
    end else if (!dec_q[DecW-1]) begin
      dec_d = dec_q + DecW'({x_q, 3'b000}) - DecW'({y_q, 3'b000}) + DecW'(20);
      y_d   = y_q - 1'b1;
      x_d   = x_q + 1'b1;
    end else begin
      dec_d = dec_q + DecW'({x_q, 3'b000}) + DecW'(12);
      x_d   = x_q + 1'b1;
    end
    fin_d = !(x_d < y_d);
  end

  // A step after the circle is finished is dropped without any output.
  assign push_o    = accept && !(op_i == OpStep && fin_q);
  assign run_o.x   = x_d;
  assign run_o.y   = y_d;
  assign run_o.fin = fin_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q   <= '0;
      y_q   <= '0;
      dec_q <= '0;
      fin_q <= 1'b1;
    end else if (push_o) begin
      x_q   <= x_d;
      y_q   <= y_d;
      dec_q <= dec_d;
      fin_q <= fin_d;
    end
  end

endmodule

/* src/mcr_queue.sv */
// Two-entry queue of pending runs between the front and back ends.
// Depends on mcr_pkg.
`timescale 1ns / 1ps

module mcr_queue import mcr_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  run_t run_i,
  input  logic pop_i,
  output logic full_o,
  output logic empty_o,
  output run_t head_o
);

  run_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign head_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= run_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

/* src/mcr_back.sv */
// Back end: walks the eight octants of the head run into the output register,
// one point per cycle while the output is not stalled. Depends on mcr_pkg.
`timescale 1ns / 1ps

module mcr_back import mcr_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     empty_i,
  input  run_t                     head_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [CoordW-1:0] px_o,
  output logic signed [CoordW-1:0] py_o,
  output logic [OctW-1:0]          octant_o,
  output logic                     last_o,
  output logic                     done_res_o
);

  logic [OctW-1:0] k_q;
  logic            vld_q;
  logic            advance;
  logic            emit;
  point_t          pt;

  // The output register moves when it is empty or being taken.
  assign advance = !vld_q || !out_stall_i;
  assign emit    = advance && !empty_i;
  assign pop_o   = emit && (k_q == LastOctant);
  assign pt      = mirror(head_i.x, head_i.y, k_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q   <= '0;
      vld_q <= 1'b0;
    end else if (advance) begin
      vld_q <= !empty_i;
      if (emit) k_q <= k_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      px_o       <= pt.px;
      py_o       <= pt.py;
      octant_o   <= k_q;
      last_o     <= (k_q == LastOctant);
      done_res_o <= head_i.fin;
    end
  end

  assign out_valid_o = vld_q;

endmodule

/* src/midpoint_circle_rasterizer.sv */
// Midpoint circle rasterizer top level: front end, run queue and back end.
// Depends on mcr_pkg, mcr_front, mcr_queue and mcr_back.
`timescale 1ns / 1ps

// Usage:
// The input channel takes one transaction per item: op_i = start loads
// radius_i and begins a circle at (0, r); op_i = step advances one point.
// Each accepted item yields eight output transactions, the mirrored points in
// octant order 0 to 7, with last_o on octant 7 and done_res_o on every point
// of the final run. A step after the circle is finished yields nothing.
// The first point of an item is written into a queue entry and then into
// the output register. Throughput is one point per cycle while out_stall_i
// is low, set by the single-point output register.
// A two-run queue lets the input be accepted while earlier runs drain;
// in_stall_o rises only when both queue entries are occupied.
// When out_stall_i is high on a valid point, the output register holds it and
// the octant walk pauses. Reset empties the queue and marks no circle active.

module midpoint_circle_rasterizer import mcr_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic                     op_i,
  input  logic [9:0]               radius_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [CoordW-1:0] px_o,
  output logic signed [CoordW-1:0] py_o,
  output logic [OctW-1:0]          octant_o,
  output logic                     last_o,
  output logic                     done_res_o
);

  logic push, pop, full, empty;
  run_t run_in, head;

  mcr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .radius_i   (radius_i),
    .q_full_i   (full),
    .push_o     (push),
    .run_o      (run_in)
  );

  mcr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .run_i   (run_in),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  mcr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .px_o        (px_o),
    .py_o        (py_o),
    .octant_o    (octant_o),
    .last_o      (last_o),
    .done_res_o  (done_res_o)
  );

endmodule
